// File: design/two_class_request_queue_defines.svh
// assertion macros shared by the queue modules
// the enclosing module provides clk_i and rst_ni
`ifndef TWO_CLASS_REQUEST_QUEUE_DEFINES_SVH
`define TWO_CLASS_REQUEST_QUEUE_DEFINES_SVH
`ifndef SYNTH
// check while out of reset
`define TCRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check on every edge, reset included
`define TCRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define TCRQ_ASSERT(lbl, prop, msg)
`define TCRQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: design/tcrq_pkg.sv
package tcrq_pkg;

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int CNT_W     = 6;
  localparam int CAP_W     = 6;
  localparam int RUN_W     = 8;
  localparam int POS_W     = 5;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  // register reset values and limits
  localparam logic [CAP_W-1:0] CAP_RST   = 6'd32;
  localparam logic [RUN_W-1:0] BURST_RST = 8'd10;
  localparam logic [RUN_W-1:0] RUN_MAX   = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_CLAMP = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 1'b0,
    CFG_BURST    = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_HOLD = 1'b1
  } ctl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic    push_prio;
    logic    push_norm;
    logic    pop_prio;
    logic    pop_norm;
    logic    rd_en;
    logic    rd_peek;
    logic    rd_prio;
    logic    load_out;
    logic    out_mem;
    logic    out_from;
    status_e out_status;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic prio_empty;
    logic norm_empty;
    logic prio_over;
    logic norm_over;
    logic total_zero;
    logic full;
    logic run_ok;
  } dp_stat_t;

endpackage

// File: design/tcrq_ctrl.sv
`include "two_class_request_queue_defines.svh"

module tcrq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic [tcrq_pkg::OP_W-1:0]  op_i,
  input  logic                       is_simple_i,
  input  logic                       queue_select_i,
  input  tcrq_pkg::dp_stat_t         stat_i,
  output tcrq_pkg::ctl_cmd_t         cmd_o
);
  import tcrq_pkg::*;

  ctl_state_e state_q, state_d;
  logic       accept;
  logic       sel_empty;
  logic       sel_over;
  op_e        op;

  assign op     = op_e'(op_i);
  assign accept = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CTL_IDLE: begin
        if (accept) state_d = CTL_HOLD;
      end
      CTL_HOLD: begin
        if (accept) begin
          state_d = CTL_HOLD;
        end else if (out_ready_i) begin
          state_d = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  // handshake outputs: a held result may drain in the accept cycle
  always_comb begin
    in_ready_o  = (state_q == CTL_IDLE) || out_ready_i;
    out_valid_o = (state_q == CTL_HOLD);
  end

  // operation decode
  assign sel_empty = queue_select_i ? stat_i.prio_empty : stat_i.norm_empty;
  assign sel_over  = queue_select_i ? stat_i.prio_over : stat_i.norm_over;

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = ST_OK;
    if (accept) begin
      cmd_o.load_out = 1'b1;
      case (op)
        OP_ENQ: begin
          if (stat_i.full) begin
            cmd_o.out_status = ST_FULL;
          end else if (is_simple_i) begin
            cmd_o.push_prio = 1'b1;
          end else begin
            cmd_o.push_norm = 1'b1;
          end
        end
        OP_DEQ: begin
          if (stat_i.total_zero) begin
            cmd_o.out_status = ST_EMPTY;
          end else if (!stat_i.prio_empty && (stat_i.norm_empty || stat_i.run_ok)) begin
            cmd_o.pop_prio = 1'b1;
            cmd_o.rd_en    = 1'b1;
            cmd_o.rd_prio  = 1'b1;
            cmd_o.out_mem  = 1'b1;
            cmd_o.out_from = 1'b1;
          end else begin
            cmd_o.pop_norm = 1'b1;
            cmd_o.rd_en    = 1'b1;
            cmd_o.out_mem  = 1'b1;
          end
        end
        OP_PEEK: begin
          if (sel_empty) begin
            cmd_o.out_status = ST_EMPTY;
          end else begin
            cmd_o.rd_en      = 1'b1;
            cmd_o.rd_peek    = 1'b1;
            cmd_o.rd_prio    = queue_select_i;
            cmd_o.out_mem    = 1'b1;
            cmd_o.out_from   = queue_select_i;
            cmd_o.out_status = sel_over ? ST_CLAMP : ST_OK;
          end
        end
        default: begin
          cmd_o.out_status = ST_OK;
        end
      endcase
    end
  end

  // a stalled result is never overwritten
  `TCRQ_ASSERT(a_no_overwrite, (state_q == CTL_HOLD && !out_ready_i) |-> !cmd_o.load_out, "result overwritten while stalled")

endmodule

// File: design/tcrq_dpath.sv
`include "two_class_request_queue_defines.svh"

module tcrq_dpath #(
  parameter int DEPTH  = 32,
  parameter int ITEM_W = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tcrq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcrq_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [ITEM_W-1:0]               item_data_i,
  input  logic [tcrq_pkg::POS_W-1:0]      position_i,
  input  tcrq_pkg::ctl_cmd_t              cmd_i,
  output tcrq_pkg::dp_stat_t              stat_o,
  output logic [ITEM_W-1:0]               result_data_o,
  output logic                            from_priority_o,
  output logic [tcrq_pkg::ST_W-1:0]       status_o,
  output logic [tcrq_pkg::CNT_W-1:0]      total_count_o
);
  import tcrq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  // ring index: base plus offset, both below the depth
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[PTR_W-1:0];
  endfunction

  logic [ITEM_W-1:0] prio_mem [DEPTH];
  logic [ITEM_W-1:0] norm_mem [DEPTH];
  logic [ITEM_W-1:0] prio_rd_q, norm_rd_q;

  logic [CAP_W-1:0]  cap_q;
  logic [RUN_W-1:0]  burst_q;
  logic [PTR_W-1:0]  p_head_q, n_head_q, p_head_d, n_head_d;
  logic [CNT_W-1:0]  p_items_q, n_items_q, p_items_d, n_items_d;
  logic [RUN_W-1:0]  run_q, run_d;

  logic [CNT_W-1:0]  total, cap_eff, limit;
  logic [CNT_W-1:0]  p_idx, n_idx;
  logic [PTR_W-1:0]  p_tail, n_tail, rd_addr;

  logic              out_mem_q, out_from_q;
  status_e           out_status_q;
  logic [CNT_W-1:0]  out_total_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RST;
      burst_q <= BURST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CAPACITY: cap_q   <= cfg_data_i[CAP_W-1:0];
        CFG_BURST:    burst_q <= cfg_data_i[RUN_W-1:0];
        default:      cap_q   <= cap_q;
      endcase
    end
  end

  // occupancy and acceptance limit
  assign total = CNT_W'(p_items_q + n_items_q);

  always_comb begin
    if (32'(cap_q) < DEPTH) begin
      cap_eff = CNT_W'(cap_q);
    end else begin
      cap_eff = CNT_W'(DEPTH);
    end
    limit = (cap_eff == '0) ? '0 : cap_eff - CNT_W'(1);
  end

  // status toward the controller
  always_comb begin
    stat_o.prio_empty = (p_items_q == '0);
    stat_o.norm_empty = (n_items_q == '0);
    stat_o.prio_over  = (CNT_W'(position_i) >= p_items_q);
    stat_o.norm_over  = (CNT_W'(position_i) >= n_items_q);
    stat_o.total_zero = (total == '0);
    stat_o.full       = (total >= limit);
    stat_o.run_ok     = (run_q <= burst_q);
  end

  // addresses: write at tail, read at head or peek position
  assign p_tail = wrap_add(p_head_q, p_items_q);
  assign n_tail = wrap_add(n_head_q, n_items_q);
  assign p_idx  = stat_o.prio_over ? p_items_q - CNT_W'(1) : CNT_W'(position_i);
  assign n_idx  = stat_o.norm_over ? n_items_q - CNT_W'(1) : CNT_W'(position_i);

  always_comb begin
    if (cmd_i.rd_prio) begin
      rd_addr = cmd_i.rd_peek ? wrap_add(p_head_q, p_idx) : p_head_q;
    end else begin
      rd_addr = cmd_i.rd_peek ? wrap_add(n_head_q, n_idx) : n_head_q;
    end
  end

  // priority store
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_prio) prio_mem[p_tail] <= item_data_i;
    if (cmd_i.rd_en && cmd_i.rd_prio) prio_rd_q <= prio_mem[rd_addr];
  end

  // normal store
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_norm) norm_mem[n_tail] <= item_data_i;
    if (cmd_i.rd_en && !cmd_i.rd_prio) norm_rd_q <= norm_mem[rd_addr];
  end

  // pointer, count and run updates
  always_comb begin
    p_head_d  = p_head_q;
    n_head_d  = n_head_q;
    p_items_d = p_items_q;
    n_items_d = n_items_q;
    run_d     = run_q;
    if (cmd_i.push_prio) p_items_d = p_items_q + CNT_W'(1);
    if (cmd_i.push_norm) n_items_d = n_items_q + CNT_W'(1);
    if (cmd_i.pop_prio) begin
      p_items_d = p_items_q - CNT_W'(1);
      p_head_d  = (p_head_q == LAST_PTR) ? '0 : p_head_q + PTR_W'(1);
      if (run_q != RUN_MAX) run_d = run_q + RUN_W'(1);
    end
    if (cmd_i.pop_norm) begin
      n_items_d = n_items_q - CNT_W'(1);
      n_head_d  = (n_head_q == LAST_PTR) ? '0 : n_head_q + PTR_W'(1);
      run_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_head_q  <= '0;
      n_head_q  <= '0;
      p_items_q <= '0;
      n_items_q <= '0;
      run_q     <= '0;
    end else begin
      p_head_q  <= p_head_d;
      n_head_q  <= n_head_d;
      p_items_q <= p_items_d;
      n_items_q <= n_items_d;
      run_q     <= run_d;
    end
  end

  // result register; data comes from the registered store read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_mem_q    <= cmd_i.out_mem;
      out_from_q   <= cmd_i.out_from;
      out_status_q <= cmd_i.out_status;
      out_total_q  <= CNT_W'(p_items_d + n_items_d);
    end
  end

  assign result_data_o   = out_mem_q ? (out_from_q ? prio_rd_q : norm_rd_q) : '0;
  assign from_priority_o = out_from_q;
  assign status_o        = out_status_q;
  assign total_count_o   = out_total_q;

  `TCRQ_ASSERT(a_push_room, (cmd_i.push_prio || cmd_i.push_norm) |-> !stat_o.full, "push past the acceptance limit")
  `TCRQ_ASSERT(a_norm_pop_run, cmd_i.pop_norm |=> (run_q == '0), "priority run not cleared by normal pop")
  `TCRQ_ASSERT(a_total_out, cmd_i.load_out |=> (total_count_o == CNT_W'(p_items_q + n_items_q)), "reported total differs from held items")
  `TCRQ_ASSERT(a_fits, (32'(p_items_q) + 32'(n_items_q)) < DEPTH, "held items exceed store depth")

endmodule

// File: design/two_class_request_queue.sv
// Two-class request queue: simple commands go to a priority FIFO and normal
// transfers to a normal FIFO, both sharing one capacity (at most capacity-1
// items, capacity capped at DEPTH). Dequeue serves priority while the run of
// consecutive priority dequeues is at most burst_limit, then one normal item,
// which clears the run. Each accepted operation gives exactly one result; it
// is valid on the cycle after acceptance, since dequeue and peek data come from
// a registered read of the store. One operation is taken per cycle as long as
// results are taken, so the block sustains one item per clock; a stalled
// result holds off only the next operation. Both stores are flop arrays of DEPTH entries
// with no clearing pass: only entries holding items are read. Configuration is written through
// cfg_we_i/cfg_idx_i/cfg_data_i by the user only while idle; the block does not enforce it.

module two_class_request_queue #(
  parameter int DEPTH  = 32,
  parameter int ITEM_W = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tcrq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcrq_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tcrq_pkg::OP_W-1:0]       op_i,
  input  logic                            is_simple_i,
  input  logic [ITEM_W-1:0]               item_data_i,
  input  logic                            queue_select_i,
  input  logic [tcrq_pkg::POS_W-1:0]      position_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ITEM_W-1:0]               result_data_o,
  output logic                            from_priority_o,
  output logic [tcrq_pkg::ST_W-1:0]       status_o,
  output logic [tcrq_pkg::CNT_W-1:0]      total_count_o
);
  import tcrq_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencing and operation decode
  tcrq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .op_i           (op_i),
    .is_simple_i    (is_simple_i),
    .queue_select_i (queue_select_i),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  // stores, pointers, counters and result register
  tcrq_dpath #(
    .DEPTH  (DEPTH),
    .ITEM_W (ITEM_W)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .item_data_i     (item_data_i),
    .position_i      (position_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .result_data_o   (result_data_o),
    .from_priority_o (from_priority_o),
    .status_o        (status_o),
    .total_count_o   (total_count_o)
  );

endmodule

// File: bench/two_class_request_queue_tb.sv
module two_class_request_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcrq_pkg::*;

  localparam int QDEPTH = 32;
  localparam int DATA_W = 32;
  localparam int CYCLE_LIMIT = 300000;

  // one queue operation as presented on the input channel
  typedef struct {
    op_e               op;
    logic              is_simple;
    logic [DATA_W-1:0] data;
    logic              qsel;
    logic [POS_W-1:0]  pos;
  } queue_op_t;

  // one result as seen on the output channel
  typedef struct {
    logic [DATA_W-1:0] data;
    logic              from_prio;
    status_e           status;
    logic [CNT_W-1:0]  total;
  } queue_rsp_t;

  // directed plan row: either a register update or an operation
  typedef struct {
    logic             is_cfg;
    logic [CAP_W-1:0] cap;
    logic [RUN_W-1:0] burst;
    queue_op_t        req;
    logic             has_known;
    queue_rsp_t       known;
  } plan_row_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_CAPACITY;
  logic [CFG_W-1:0]    cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     op_i           = OP_NOP;
  logic                is_simple_i    = 1'b0;
  logic [DATA_W-1:0]   item_data_i    = '0;
  logic                queue_select_i = 1'b0;
  logic [POS_W-1:0]    position_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic [DATA_W-1:0]   result_data_o;
  logic                from_priority_o;
  logic [ST_W-1:0]     status_o;
  logic [CNT_W-1:0]    total_count_o;

  two_class_request_queue #(
    .DEPTH  (QDEPTH),
    .ITEM_W (DATA_W)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .is_simple_i     (is_simple_i),
    .item_data_i     (item_data_i),
    .queue_select_i  (queue_select_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_data_o   (result_data_o),
    .from_priority_o (from_priority_o),
    .status_o        (status_o),
    .total_count_o   (total_count_o)
  );

  // shadow copy of both fifos and the arbitration state
  logic [DATA_W-1:0] prio_mem [QDEPTH];
  logic [DATA_W-1:0] norm_mem [QDEPTH];
  logic [POS_W-1:0]  prio_head = '0;
  logic [POS_W-1:0]  norm_head = '0;
  int unsigned       prio_cnt  = 0;
  int unsigned       norm_cnt  = 0;
  int unsigned       prio_run  = 0;
  int unsigned       cap_reg   = CAP_RST;
  int unsigned       burst_reg = BURST_RST;

  queue_rsp_t  pending_rsp [$];
  int          mismatch_cnt = 0;
  int          cycle_cnt    = 0;
  bit          steady       = 1'b0;
  plan_row_t   plan [$];

  // compute the result of one operation and advance the shadow state
  function automatic queue_rsp_t apply_queue_op(queue_op_t rq);
    queue_rsp_t  rsp;
    int unsigned eff_cap;
    int unsigned admit_max;
    int unsigned held;
    int unsigned idx;
    rsp.data      = '0;
    rsp.from_prio = 1'b0;
    rsp.status    = ST_OK;
    eff_cap   = (cap_reg < QDEPTH) ? cap_reg : QDEPTH;
    admit_max = (eff_cap > 0) ? eff_cap - 1 : 0;
    held      = prio_cnt + norm_cnt;
    case (rq.op)
      OP_ENQ: begin
        if (held >= admit_max) begin
          rsp.status = ST_FULL;
        end else if (rq.is_simple) begin
          prio_mem[prio_head + POS_W'(prio_cnt)] = rq.data;
          prio_cnt++;
        end else begin
          norm_mem[norm_head + POS_W'(norm_cnt)] = rq.data;
          norm_cnt++;
        end
      end
      OP_DEQ: begin
        if (held == 0) begin
          rsp.status = ST_EMPTY;
        end else if (prio_cnt > 0 && (norm_cnt == 0 || prio_run <= burst_reg)) begin
          rsp.data      = prio_mem[prio_head];
          rsp.from_prio = 1'b1;
          prio_head++;
          prio_cnt--;
          if (prio_run < RUN_MAX) prio_run++;
        end else begin
          rsp.data = norm_mem[norm_head];
          norm_head++;
          norm_cnt--;
          prio_run = 0;
        end
      end
      OP_PEEK: begin
        held = rq.qsel ? prio_cnt : norm_cnt;
        if (held == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          idx = rq.pos;
          // past the tail: clamp to the last entry
          if (idx >= held) begin
            idx        = held - 1;
            rsp.status = ST_CLAMP;
          end
          rsp.data      = rq.qsel ? prio_mem[prio_head + POS_W'(idx)]
                                  : norm_mem[norm_head + POS_W'(idx)];
          rsp.from_prio = rq.qsel;
        end
      end
      default: ;
    endcase
    rsp.total = CNT_W'(prio_cnt + norm_cnt);
    return rsp;
  endfunction

  function automatic plan_row_t op_row(op_e op, logic simple, logic [DATA_W-1:0] data,
                                       logic qsel, logic [POS_W-1:0] pos, logic known,
                                       logic [DATA_W-1:0] rdata, logic rprio,
                                       status_e rst, logic [CNT_W-1:0] rtotal);
    plan_row_t row;
    row.is_cfg          = 1'b0;
    row.cap             = '0;
    row.burst           = '0;
    row.req.op          = op;
    row.req.is_simple   = simple;
    row.req.data        = data;
    row.req.qsel        = qsel;
    row.req.pos         = pos;
    row.has_known       = known;
    row.known.data      = rdata;
    row.known.from_prio = rprio;
    row.known.status    = rst;
    row.known.total     = rtotal;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [CAP_W-1:0] cap, logic [RUN_W-1:0] burst);
    plan_row_t row;
    row           = op_row(OP_NOP, 1'b0, '0, 1'b0, '0, 1'b0, '0, 1'b0, ST_OK, '0);
    row.is_cfg    = 1'b1;
    row.cap       = cap;
    row.burst     = burst;
    return row;
  endfunction

  // random operation, mostly well formed with random payload
  function automatic queue_op_t random_queue_op(int enq_pct, int simple_pm);
    queue_op_t   rq;
    int          pick;
    int unsigned fill;
    rq.is_simple = ($urandom_range(0, 999) < simple_pm);
    rq.data      = $urandom();
    rq.qsel      = $urandom_range(0, 1);
    rq.pos       = $urandom_range(0, 31);
    pick         = $urandom_range(0, 99);
    if (pick < 3) begin
      rq.op = OP_NOP;
    end else if (pick < 15) begin
      rq.op = OP_PEEK;
      fill  = rq.qsel ? prio_cnt : norm_cnt;
      if (fill > 0 && $urandom_range(0, 1) == 1) rq.pos = $urandom_range(0, fill - 1);
    end else if (pick < 15 + enq_pct) begin
      rq.op = OP_ENQ;
    end else begin
      rq.op = OP_DEQ;
    end
    return rq;
  endfunction

  // drive one operation until its transfer, then queue the expected result
  task automatic send_queue_op(queue_op_t rq, logic has_known, queue_rsp_t known);
    queue_rsp_t predicted;
    if (!steady && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= rq.op;
    is_simple_i    <= rq.is_simple;
    item_data_i    <= rq.data;
    queue_select_i <= rq.qsel;
    position_i     <= rq.pos;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_queue_op(rq);
    pending_rsp.push_back(has_known ? known : predicted);
  endtask

  // stop sending and wait until every expected result is in
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // register writes only with all expected results drained
  task automatic write_regs(logic [CAP_W-1:0] cap, logic [RUN_W-1:0] burst);
    drain_results();
    repeat (3) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CAPACITY;
    cfg_data_i <= {2'($urandom_range(0, 3)), cap};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BURST;
    cfg_data_i <= burst;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cap_reg    = cap;
    burst_reg  = burst;
  endtask

  task automatic run_phase(int cap, int burst, int count, int enq_pct, int simple_pm,
                           bit hold_midway);
    queue_rsp_t unused_rsp;
    unused_rsp = '{data: '0, from_prio: 1'b0, status: ST_OK, total: '0};
    write_regs(CAP_W'(cap), RUN_W'(burst));
    for (int i = 0; i < count; i++) begin
      if (hold_midway && i == count / 2) drain_results();
      send_queue_op(random_queue_op(enq_pct, simple_pm), 1'b0, unused_rsp);
    end
  endtask

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result side backpressure
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!steady && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    queue_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result: result_data %h status %0d", result_data_o, status_o);
        mismatch_cnt++;
      end else begin
        want = pending_rsp.pop_front();
        if (result_data_o !== want.data) begin
          $error("result_data: expected %h, got %h", want.data, result_data_o);
          mismatch_cnt++;
        end
        if (from_priority_o !== want.from_prio) begin
          $error("from_priority: expected %0d, got %0d", want.from_prio, from_priority_o);
          mismatch_cnt++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_cnt++;
        end
        if (total_count_o !== want.total) begin
          $error("total_count: expected %0d, got %0d", want.total, total_count_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    // empty queue, reset registers
    plan.push_back(op_row(OP_DEQ,  1'b0, 32'h0, 1'b0, 5'd0, 1'b1, 32'h0, 1'b0, ST_EMPTY, 6'd0));
    plan.push_back(op_row(OP_PEEK, 1'b0, 32'h0, 1'b1, 5'd0, 1'b1, 32'h0, 1'b0, ST_EMPTY, 6'd0));
    plan.push_back(op_row(OP_PEEK, 1'b1, 32'h0, 1'b0, 5'd31, 1'b1, 32'h0, 1'b0, ST_EMPTY, 6'd0));
    plan.push_back(op_row(OP_NOP,  1'b0, 32'h0, 1'b0, 5'd0, 1'b1, 32'h0, 1'b0, ST_OK, 6'd0));
    // fill both classes with extreme payloads
    plan.push_back(op_row(OP_ENQ,  1'b1, 32'hFFFF_FFFF, 1'b0, 5'd0, 1'b1,
                          32'h0, 1'b0, ST_OK, 6'd1));
    plan.push_back(op_row(OP_ENQ,  1'b0, 32'h0, 1'b1, 5'd31, 1'b1, 32'h0, 1'b0, ST_OK, 6'd2));
    plan.push_back(op_row(OP_ENQ,  1'b1, 32'hA5A5_A5A5, 1'b0, 5'd0, 1'b1,
                          32'h0, 1'b0, ST_OK, 6'd3));
    // peeks: head, clamped past the tail on both fifos, and one at the last priority entry
    plan.push_back(op_row(OP_PEEK, 1'b0, 32'h0, 1'b1, 5'd0, 1'b1,
                          32'hFFFF_FFFF, 1'b1, ST_OK, 6'd3));
    plan.push_back(op_row(OP_PEEK, 1'b0, 32'h0, 1'b1, 5'd31, 1'b1,
                          32'hA5A5_A5A5, 1'b1, ST_CLAMP, 6'd3));
    plan.push_back(op_row(OP_PEEK, 1'b1, 32'hFFFF_FFFF, 1'b0, 5'd31, 1'b1,
                          32'h0, 1'b0, ST_CLAMP, 6'd3));
    plan.push_back(op_row(OP_PEEK, 1'b0, 32'h0, 1'b1, 5'd1, 1'b0, 32'h0, 1'b0, ST_OK, 6'd0));
    // unused op with every other field high
    plan.push_back(op_row(OP_NOP,  1'b1, 32'hFFFF_FFFF, 1'b1, 5'd31, 1'b1,
                          32'h0, 1'b0, ST_OK, 6'd3));
    // priority first, then normal once priority is gone
    plan.push_back(op_row(OP_DEQ,  1'b0, 32'h0, 1'b0, 5'd0, 1'b1,
                          32'hFFFF_FFFF, 1'b1, ST_OK, 6'd2));
    plan.push_back(op_row(OP_DEQ,  1'b0, 32'h0, 1'b0, 5'd0, 1'b1,
                          32'hA5A5_A5A5, 1'b1, ST_OK, 6'd1));
    plan.push_back(op_row(OP_DEQ,  1'b0, 32'h0, 1'b0, 5'd0, 1'b1, 32'h0, 1'b0, ST_OK, 6'd0));
    plan.push_back(op_row(OP_DEQ,  1'b1, 32'h0, 1'b1, 5'd31, 1'b1,
                          32'h0, 1'b0, ST_EMPTY, 6'd0));
    // smallest useful capacity: one item, then refused
    plan.push_back(cfg_row(6'd2, 8'd0));
    plan.push_back(op_row(OP_ENQ,  1'b0, 32'h1234_5678, 1'b0, 5'd0, 1'b1,
                          32'h0, 1'b0, ST_OK, 6'd1));
    plan.push_back(op_row(OP_ENQ,  1'b1, 32'h0000_0001, 1'b0, 5'd0, 1'b1,
                          32'h0, 1'b0, ST_FULL, 6'd1));
    // zero capacity refuses everything but the held item still drains
    plan.push_back(cfg_row(6'd0, 8'd255));
    plan.push_back(op_row(OP_ENQ,  1'b0, 32'hDEAD_BEEF, 1'b0, 5'd0, 1'b1,
                          32'h0, 1'b0, ST_FULL, 6'd1));
    plan.push_back(op_row(OP_DEQ,  1'b0, 32'h0, 1'b0, 5'd0, 1'b1,
                          32'h1234_5678, 1'b0, ST_OK, 6'd0));
    plan.push_back(op_row(OP_ENQ,  1'b1, 32'h8000_0000, 1'b0, 5'd0, 1'b1,
                          32'h0, 1'b0, ST_FULL, 6'd0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_regs(plan[i].cap, plan[i].burst);
      else send_queue_op(plan[i].req, plan[i].has_known, plan[i].known);
    end

    // random phases across register settings
    run_phase(32, 10, 130, 45, 500, 1'b1);
    run_phase(2, 0, 60, 45, 500, 1'b0);
    run_phase(63, 255, 80, 60, 500, 1'b0);
    run_phase(0, 1, 20, 50, 500, 1'b0);
    run_phase(1, 3, 20, 50, 500, 1'b0);
    // long priority runs: the run counter has to saturate
    run_phase(32, 200, 650, 43, 995, 1'b0);
    run_phase($urandom_range(2, 32), 0, 60, 45, 500, 1'b0);
    write_regs(6'd5, 8'd2);
    steady = 1'b1;
    run_phase(5, 2, 60, 45, 500, 1'b0);

    drain_results();
    repeat (5) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/tcrq_pkg.sv
design/tcrq_ctrl.sv
design/tcrq_dpath.sv
design/two_class_request_queue.sv
bench/two_class_request_queue_tb.sv
